// ----- sv/assert_macros.svh -----
// Assertion helpers. Both macros use the clk and rst names of the module
// that includes this file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

// ----- sv/ltt_pkg.sv -----
package ltt_pkg;

  // Table geometry
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // latch request, read hinted slot, arm the scan
    logic hint_chk;  // compare the hinted slot
    logic scan_run;  // issue one scan read and compare the one in flight
    logic apply;     // update the table and load the result register
  } ltt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_none;    // incoming request has an unused kind
    logic hint_ok;    // hint names a written slot
    logic hint_hit;   // hinted slot matches the request key
    logic scan_hit;   // slot in flight matches the request key
    logic scan_done;  // every written slot has been compared
    logic req_cancel; // current request is a cancel
    logic out_free;   // result register can take a new result
  } ltt_stat_t;

endpackage

// ----- sv/ltt_ctrl.sv -----
module ltt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ltt_pkg::ltt_stat_t stat,
  output ltt_pkg::ltt_cmd_t  cmd
);
  import ltt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HINT  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Take a request only while idle
  assign in_ready = (state == S_IDLE);

  // One request: hint check, else newest-first scan, then apply
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.in_none) begin
            state_next = S_APPLY;
          end else if (stat.hint_ok) begin
            state_next = S_HINT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_HINT: begin
        cmd.hint_chk = 1'b1;
        if (stat.hint_hit) begin
          state_next = S_APPLY;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        // A cancel keeps going to clear every match
        if ((stat.scan_hit && !stat.req_cancel) || stat.scan_done) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        // Hold until the result register is free
        if (stat.out_free) begin
          cmd.apply  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/ltt_datapath.sv -----
`include "assert_macros.svh"

module ltt_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  ltt_pkg::ltt_cmd_t           cmd,
  output ltt_pkg::ltt_stat_t          stat,
  input  logic [1:0]                  in_kind,
  input  logic [31:0]                 in_key,
  input  logic [31:0]                 in_tail,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found,
  output logic [ltt_pkg::DATA_W-1:0]  tail_out,
  output logic [ltt_pkg::DATA_W-1:0]  count_out,
  output logic                        created,
  output logic                        table_full
);
  import ltt_pkg::*;

  // Table storage, valid only below used_slots
  logic [KEY_W-1:0]  key_mem   [DEPTH];
  logic [DATA_W-1:0] tail_mem  [DEPTH];
  logic [DATA_W-1:0] count_mem [DEPTH];

  // Request
  kind_t             req_kind;
  logic [KEY_W-1:0]  req_key;
  logic [DATA_W-1:0] req_tail;

  // Table control state
  logic [CNT_W-1:0]  used_slots;
  logic [ADDR_W-1:0] hint_index;
  logic              hint_valid;

  // Scan state
  logic [CNT_W-1:0]  scan_idx;
  logic [CNT_W-1:0]  scan_dec;
  logic              scan_issue;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;

  // Registered read data
  logic [KEY_W-1:0]  key_q;
  logic [DATA_W-1:0] tail_q;
  logic [DATA_W-1:0] count_q;

  // Match capture
  logic              hit_flag;
  logic [ADDR_W-1:0] match_slot;
  logic [DATA_W-1:0] hit_tail;
  logic [DATA_W-1:0] hit_count;
  logic [DATA_W-1:0] sat_count;

  // Memory port controls
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              key_we;
  logic [ADDR_W-1:0] key_waddr;
  logic [KEY_W-1:0]  key_wdata;
  logic              tc_we;
  logic [ADDR_W-1:0] tc_waddr;
  logic [DATA_W-1:0] tail_wdata;
  logic [DATA_W-1:0] count_wdata;

  logic              key_eq;
  logic              room;
  logic              scan_hit;
  logic              res_found;
  logic [DATA_W-1:0] res_tail;
  logic [DATA_W-1:0] res_count;
  logic              res_created;
  logic              res_full;

  // Compare and status
  assign key_eq    = (key_q == req_key);
  assign scan_hit  = pend && key_eq;
  assign room      = (used_slots < CNT_W'(DEPTH));
  assign scan_dec  = scan_idx - 1'b1;
  assign scan_issue = cmd.scan_run && (scan_idx != '0);
  assign sat_count = (hit_count == '1) ? hit_count : hit_count + 1'b1;

  assign stat.in_none    = (kind_t'(in_kind) == KIND_NONE);
  assign stat.hint_ok    = hint_valid && (CNT_W'(hint_index) < used_slots);
  assign stat.hint_hit   = key_eq;
  assign stat.scan_hit   = scan_hit;
  assign stat.scan_done  = !pend && (scan_idx == '0);
  assign stat.req_cancel = (req_kind == KIND_CANCEL);
  assign stat.out_free   = !out_valid || out_ready;

  // Read the hinted slot on accept, else the next slot of the scan
  assign rd_en   = cmd.accept || scan_issue;
  assign rd_addr = cmd.accept ? hint_index : scan_dec[ADDR_W-1:0];

  // Write port selection
  always_comb begin
    key_we      = 1'b0;
    key_waddr   = match_slot;
    key_wdata   = '0;
    tc_we       = 1'b0;
    tc_waddr    = match_slot;
    tail_wdata  = req_tail;
    count_wdata = sat_count;
    if (cmd.scan_run && scan_hit && req_kind == KIND_CANCEL) begin
      // Clear every match met during a cancel scan
      key_we    = 1'b1;
      key_waddr = pend_addr;
    end else if (cmd.apply) begin
      case (req_kind)
        KIND_UPDATE: begin
          if (hit_flag) begin
            tc_we = 1'b1;
          end else if (room) begin
            key_we      = 1'b1;
            key_waddr   = used_slots[ADDR_W-1:0];
            key_wdata   = req_key;
            tc_we       = 1'b1;
            tc_waddr    = used_slots[ADDR_W-1:0];
            count_wdata = DATA_W'(1);
          end
        end
        KIND_CANCEL: begin
          key_we = hit_flag;
        end
        default: begin
          key_we = 1'b0;
        end
      endcase
    end
  end

  // Result of the current request
  always_comb begin
    res_found   = 1'b0;
    res_tail    = '0;
    res_count   = '0;
    res_created = 1'b0;
    res_full    = 1'b0;
    case (req_kind)
      KIND_UPDATE: begin
        if (hit_flag) begin
          res_found = 1'b1;
          res_tail  = req_tail;
          res_count = sat_count;
        end else if (room) begin
          res_tail    = req_tail;
          res_count   = DATA_W'(1);
          res_created = 1'b1;
        end else begin
          res_full = 1'b1;
        end
      end
      KIND_LOOKUP: begin
        if (hit_flag) begin
          res_found = 1'b1;
          res_tail  = hit_tail;
          res_count = hit_count;
        end
      end
      KIND_CANCEL: begin
        res_found = hit_flag;
      end
      default: begin
        res_found = 1'b0;
      end
    endcase
  end

  // Table memories with registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      key_q   <= key_mem[rd_addr];
      tail_q  <= tail_mem[rd_addr];
      count_q <= count_mem[rd_addr];
    end
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (tc_we) begin
      tail_mem[tc_waddr]  <= tail_wdata;
      count_mem[tc_waddr] <= count_wdata;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_kind <= kind_t'(in_kind);
      req_key  <= in_key[KEY_W-1:0];
      req_tail <= in_tail;
    end
    if (cmd.scan_run) begin
      pend_addr <= scan_dec[ADDR_W-1:0];
    end
    if (cmd.hint_chk && key_eq) begin
      match_slot <= hint_index;
      hit_tail   <= tail_q;
      hit_count  <= count_q;
    end else if (cmd.scan_run && scan_hit) begin
      match_slot <= pend_addr;
      hit_tail   <= tail_q;
      hit_count  <= count_q;
    end
    if (cmd.apply) begin
      found      <= res_found;
      tail_out   <= res_tail;
      count_out  <= res_count;
      created    <= res_created;
      table_full <= res_full;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      used_slots <= '0;
      hint_index <= '0;
      hint_valid <= 1'b0;
      scan_idx   <= '0;
      pend       <= 1'b0;
      hit_flag   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Load a new result, else drop the old one once taken
      if (cmd.apply) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.accept) begin
        hit_flag <= 1'b0;
        scan_idx <= used_slots;
        pend     <= 1'b0;
      end
      if (cmd.hint_chk && key_eq) begin
        hit_flag <= 1'b1;
      end
      // Advance the scan one slot toward the oldest
      if (cmd.scan_run) begin
        pend <= scan_issue;
        if (scan_issue) begin
          scan_idx <= scan_dec;
        end
        if (scan_hit) begin
          hit_flag <= 1'b1;
        end
      end
      if (cmd.apply) begin
        case (req_kind)
          KIND_UPDATE: begin
            if (hit_flag) begin
              hint_index <= match_slot;
              hint_valid <= 1'b1;
            end else if (room) begin
              hint_index <= used_slots[ADDR_W-1:0];
              hint_valid <= 1'b1;
              used_slots <= used_slots + 1'b1;
            end
          end
          KIND_LOOKUP: begin
            if (hit_flag) begin
              hint_index <= match_slot;
              hint_valid <= 1'b1;
            end
          end
          KIND_CANCEL: begin
            if (hit_flag) begin
              hint_valid <= 1'b0;
            end
          end
          default: begin
            hint_valid <= hint_valid;
          end
        endcase
      end
    end
  end

  `ASSERT_CLK(a_used_bound, used_slots <= CNT_W'(DEPTH))
  `ASSERT_CLK(a_hint_in_range, hint_valid |-> (CNT_W'(hint_index) < used_slots))
  `ASSERT_CLK(a_apply_free, cmd.apply |-> (!out_valid || out_ready))
  `ASSERT_CLK(a_cancel_drops_hint, (cmd.apply && req_kind == KIND_CANCEL && hit_flag) |=> !hint_valid)
  `ASSERT_CLK(a_append_grows, (cmd.apply && req_kind == KIND_UPDATE && !hit_flag && room) |=> (used_slots == $past(used_slots) + 1'b1))

endmodule

// ----- sv/list_tail_tracker_table.sv -----
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata {tail_in, key}, tuser kind
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata {count_out, tail_out},
//                                               tuser {table_full, created, found}
//
// A request whose key matches the hint (the slot of the last hit or append) is
// checked against that slot alone; otherwise the scan reads one slot per cycle
// from the newest down, over at most used_slots slots, as the table memories have
// a single read port. Unused kinds go straight to the result.
// rst is synchronous and clears counts and the hint; the table needs no clearing.
// A waiting result is held in the output register; the next request is taken
// meanwhile and waits only before its own result is loaded.
module list_tail_tracker_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] key, [63:32] tail_in
  input  logic [1:0]  s_axis_tuser,  // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // [31:0] tail_out, [63:32] count_out
  output logic [2:0]  m_axis_tuser   // [0] found, [1] created, [2] table_full
);
  import ltt_pkg::*;

  ltt_cmd_t          cmd;
  ltt_stat_t         stat;
  logic              found;
  logic              created;
  logic              table_full;
  logic [DATA_W-1:0] tail_out;
  logic [DATA_W-1:0] count_out;

  ltt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ltt_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_kind    (s_axis_tuser),
    .in_key     (s_axis_tdata[31:0]),
    .in_tail    (s_axis_tdata[63:32]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .found      (found),
    .tail_out   (tail_out),
    .count_out  (count_out),
    .created    (created),
    .table_full (table_full)
  );

  // Pack the result
  assign m_axis_tdata = {count_out, tail_out};
  assign m_axis_tuser = {table_full, created, found};

endmodule
